FILE: rtl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared widths, types and the keep-count reset constant for the streaming k-smallest block.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int SKS_VALUE_W = 32;
    localparam int SKS_KEEP_W  = 5;
    localparam int SKS_MAX_K   = 16;

    localparam logic [SKS_KEEP_W-1:0] SKS_KEEP_RESET = SKS_KEEP_W'(4);

    typedef logic signed [SKS_VALUE_W-1:0] t_value;
    typedef logic [SKS_KEEP_W-1:0]         t_keep;

endpackage

FILE: rtl/sks_in_if.sv
// ----------------------------------------------------------------------------
// sks_in_if
// Input request channel: one signed value and its end-of-set mark.
// ----------------------------------------------------------------------------
interface sks_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      value;
    logic                    end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

FILE: rtl/sks_out_if.sv
// ----------------------------------------------------------------------------
// sks_out_if
// Result request channel: one kept value and the last-of-run mark.
// ----------------------------------------------------------------------------
interface sks_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      kept_value;
    logic                    final_res;

    modport source (output valid, output kept_value, output final_res, input ready);
    modport sink   (input valid, input kept_value, input final_res, output ready);
endinterface

FILE: rtl/streaming_k_smallest.sv
// ----------------------------------------------------------------------------
// streaming_k_smallest
// Keeps the k smallest signed values of each set and emits them largest first.
// ----------------------------------------------------------------------------
// The block takes one value per cycle while no end_of_set request is held;
// each request is registered, then compared against a sorted row of MAX_K
// registers and inserted there. On a request marked end_of_set the finished
// row is copied into a drain buffer and the row is emptied, so the next set
// streams in at once. The drain buffer emits the n kept values (n = k, or
// fewer if the set was shorter) one per cycle while the output is ready,
// through an output register, largest first, with final_res on the last.
// An end_of_set request waits in the input register only while the
// previous set's drain buffer still holds values; once taken, its set goes
// to the drain buffer and the largest value on to the output register.
// keep_count is clamped to 1..MAX_K and may be written between requests.
// ----------------------------------------------------------------------------
module streaming_k_smallest #(
    parameter int MAX_K = sks_pkg::SKS_MAX_K
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sks_pkg::t_keep        i_cfg_wdata,
    sks_in_if.sink                i_in,
    sks_out_if.source             o_out
);
    import sks_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);

    t_keep           r_keep;
    logic            r_in_valid;
    t_value          r_in_value;
    logic            r_in_eos;

    logic            in_take;
    logic            load;
    logic            drain_free;
    t_value          load_row [MAX_K];
    logic [CW-1:0]   load_cnt;

    // Keep-count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= SKS_KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    // Input register: accept when empty or being consumed this cycle
    assign i_in.ready = !r_in_valid || in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_value <= i_in.value;
            r_in_eos   <= i_in.end_of_set;
        end
    end

    sks_insert #(
        .MAX_K (MAX_K)
    ) u_insert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keep_count (r_keep),
        .i_in_valid   (r_in_valid),
        .i_in_value   (r_in_value),
        .i_in_eos     (r_in_eos),
        .i_drain_free (drain_free),
        .o_in_take    (in_take),
        .o_load       (load),
        .o_load_row   (load_row),
        .o_load_cnt   (load_cnt)
    );

    sks_drain #(
        .MAX_K (MAX_K)
    ) u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_load_row   (load_row),
        .i_load_cnt   (load_cnt),
        .o_drain_free (drain_free),
        .o_out        (o_out)
    );

endmodule

FILE: rtl/sks_insert.sv
// ----------------------------------------------------------------------------
// sks_insert
// Sorted register row with combinational compare-and-insert of one value.
// ----------------------------------------------------------------------------
module sks_insert #(
    parameter int MAX_K = sks_pkg::SKS_MAX_K
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sks_pkg::t_keep        i_keep_count,
    input  logic                  i_in_valid,
    input  sks_pkg::t_value       i_in_value,
    input  logic                  i_in_eos,
    input  logic                  i_drain_free,
    output logic                  o_in_take,
    output logic                  o_load,
    output sks_pkg::t_value       o_load_row [MAX_K],
    output logic [$clog2(MAX_K+1)-1:0] o_load_cnt
);
    import sks_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    t_value          r_row [MAX_K];
    logic [CW-1:0]   r_cnt;

    t_value          n_row [MAX_K];
    logic [CW-1:0]   n_cnt;
    logic [CW-1:0]   eff_k;
    logic [CW-1:0]   cnt_trunc;
    logic [CW-1:0]   base;
    logic [IW-1:0]   top_idx;
    logic            full;
    logic            top_gt;
    logic            do_ins;
    logic [MAX_K-1:0] gt;

    // Clamp the keep count to 1..MAX_K
    always_comb begin
        if (i_keep_count == '0) begin
            eff_k = CW'(1);
        end else if (int'(i_keep_count) > MAX_K) begin
            eff_k = CW'(MAX_K);
        end else begin
            eff_k = CW'(i_keep_count);
        end
    end

    // Drop excess entries, then decide on insert or replace-largest
    always_comb begin
        cnt_trunc = (r_cnt > eff_k) ? eff_k : r_cnt;
        full      = (cnt_trunc == eff_k);
        top_idx   = IW'(cnt_trunc - CW'(1));
        top_gt    = (cnt_trunc != '0) && (r_row[top_idx] > i_in_value);
        do_ins    = !full || top_gt;
        base      = full ? (cnt_trunc - CW'(1)) : cnt_trunc;
        for (int i = 0; i < MAX_K; i++) begin
            gt[i] = (CW'(i) < base) && (r_row[i] > i_in_value);
        end
        for (int i = 0; i < MAX_K; i++) begin
            n_row[i] = r_row[i];
            if (do_ins && (gt[i] || CW'(i) == base)) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    n_row[i] = r_row[(i > 0) ? i - 1 : 0];
                end else begin
                    n_row[i] = i_in_value;
                end
            end
        end
        n_cnt = do_ins ? (base + CW'(1)) : cnt_trunc;
    end

    // Hold an end-of-set request until the drain buffer is empty
    assign o_in_take  = i_in_valid && (!i_in_eos || i_drain_free);
    assign o_load     = o_in_take && i_in_eos;
    assign o_load_row = n_row;
    assign o_load_cnt = n_cnt;

    // Advance the row; empty it when the set is handed to the drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_in_take) begin
            r_cnt <= i_in_eos ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_take) begin
            r_row <= n_row;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_K))
        else $error("held count exceeds MAX_K");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> (o_load_cnt != '0) && (o_load_cnt <= eff_k))
        else $error("set handed over with bad count");

endmodule

FILE: rtl/sks_drain.sv
// ----------------------------------------------------------------------------
// sks_drain
// Snapshot of a finished set, emitted largest first through an output register.
// ----------------------------------------------------------------------------
module sks_drain #(
    parameter int MAX_K = sks_pkg::SKS_MAX_K
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sks_pkg::t_value       i_load_row [MAX_K],
    input  logic [$clog2(MAX_K+1)-1:0] i_load_cnt,
    output logic                  o_drain_free,
    sks_out_if.source             o_out
);
    import sks_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    t_value          r_dr [MAX_K];
    logic [CW-1:0]   r_dr_cnt;
    logic            r_out_valid;
    t_value          r_out_value;
    logic            r_out_final;

    logic            mv;
    logic [IW-1:0]   rd_idx;

    assign o_drain_free = (r_dr_cnt == '0);
    assign mv           = (r_dr_cnt != '0) && (!r_out_valid || o_out.ready);
    assign rd_idx       = IW'(r_dr_cnt - CW'(1));

    // Take a new snapshot or count down as entries move out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr_cnt <= '0;
        end else if (i_load) begin
            r_dr_cnt <= i_load_cnt;
        end else if (mv) begin
            r_dr_cnt <= r_dr_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dr <= i_load_row;
        end
    end

    // Output register: fill from the top of the snapshot, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv) begin
            r_out_value <= r_dr[rd_idx];
            r_out_final <= (r_dr_cnt == CW'(1));
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kept_value = r_out_value;
    assign o_out.final_res  = r_out_final;

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_dr_cnt == '0))
        else $error("snapshot loaded over a pending drain");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv && (r_dr_cnt == CW'(1)) |=> r_out_final && (r_dr_cnt == '0 || $past(i_load)))
        else $error("final mark out of step with drain count");

endmodule

FILE: verif/streaming_k_smallest_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_k_smallest_tb
// Drives sets of signed values into the k-smallest block and checks every
// kept value and its final mark against a predictor of the sorted row.
// A directed table comes first, then random sets under four idling mixes,
// with keep_count rewritten between phases, sometimes in the middle of a set.
// ----------------------------------------------------------------------------
module streaming_k_smallest_tb;
    import sks_pkg::*;

    localparam int     DRAIN_CYCLES    = 8;
    localparam int     RAND_PHASES     = 8;
    localparam int     ITEMS_PER_PHASE = 60;
    localparam int     MAX_REPORTS     = 10;
    localparam t_value VAL_MAX         = 32'sh7FFF_FFFF;
    localparam t_value VAL_MIN         = 32'sh8000_0000;

    typedef enum logic {ROW_ITEM, ROW_KEEP} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_keep     keep;
        t_value    value;
        logic      eos;
        logic      has_exp;
        t_value    exp_value;
    } t_dir_row;

    typedef struct {
        t_value kept_value;
        logic   final_res;
    } t_kept_result;

    localparam int DIR_ROWS = 28;

    // Rows with has_exp set close a set that yields exactly one value.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, 5'd0,  32'sd5,    1'b1, 1'b1, 32'sd5},   // default k after reset
        '{ROW_KEEP, 5'd1,  32'sd0,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  VAL_MAX,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  VAL_MIN,   1'b1, 1'b1, VAL_MIN},
        '{ROW_KEEP, 5'd16, 32'sd0,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd0,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  -32'sd1,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd7,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd7,    1'b0, 1'b0, 32'sd0},   // duplicate kept
        '{ROW_ITEM, 5'd0,  VAL_MAX,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  VAL_MIN,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd3,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  -32'sd5,   1'b1, 1'b0, 32'sd0},
        '{ROW_KEEP, 5'd0,  32'sd0,    1'b0, 1'b0, 32'sd0},   // zero acts as one
        '{ROW_ITEM, 5'd0,  32'sd9,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  -32'sd9,   1'b1, 1'b1, -32'sd9},
        '{ROW_KEEP, 5'd31, 32'sd0,    1'b0, 1'b0, 32'sd0},   // saturates at max
        '{ROW_ITEM, 5'd0,  32'sd100,  1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd50,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd50,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd25,   1'b0, 1'b0, 32'sd0},
        '{ROW_KEEP, 5'd2,  32'sd0,    1'b0, 1'b0, 32'sd0},   // lower k mid-set
        '{ROW_ITEM, 5'd0,  32'sd60,   1'b1, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd8,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd8,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  32'sd8,    1'b1, 1'b0, 32'sd0},   // equal is not smaller
        '{ROW_KEEP, 5'd17, 32'sd0,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 5'd0,  -32'sd1,   1'b1, 1'b1, -32'sd1}
    };

    t_keep keep_plan [RAND_PHASES-1] = '{5'd1, 5'd16, 5'd7, 5'd0, 5'd31, 5'd3, 5'd12};
    int    send_idle_plan [4] = '{0, 70, 0, 16};
    int    recv_stall_plan [4] = '{0, 0, 70, 16};

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_keep i_cfg_wdata;

    sks_in_if  in_ch ();
    sks_out_if out_ch ();

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;

    // Predictor state: ascending row of kept values and the k register.
    t_value       held_row [SKS_MAX_K];
    int unsigned  held_n;
    t_keep        keep_reg;
    t_kept_result kept_q [$];

    streaming_k_smallest uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void queue_result(input t_value v, input logic fin_mark);
        t_kept_result item;
        item.kept_value = v;
        item.final_res  = fin_mark;
        kept_q.insert(kept_q.size(), item);
    endfunction

    // Take one value into the row; on end of set, queue the row largest first.
    function automatic void take_value(input t_value v, input logic eos);
        int unsigned k;
        int unsigned pos;
        logic        do_insert;
        k = (keep_reg == 0) ? 1 : (keep_reg > SKS_MAX_K) ? SKS_MAX_K : keep_reg;
        if (held_n > k)
            held_n = k;
        do_insert = 1'b0;
        if (held_n < k) begin
            do_insert = 1'b1;
        end else if (held_n > 0 && held_row[held_n-1] > v) begin
            held_n--;
            do_insert = 1'b1;
        end
        if (do_insert) begin
            pos = held_n;
            while (pos > 0 && held_row[pos-1] > v) begin
                held_row[pos] = held_row[pos-1];
                pos--;
            end
            held_row[pos] = v;
            held_n++;
        end
        if (eos) begin
            for (int i = 0; i < held_n; i++)
                queue_result(held_row[held_n-1-i], (i == held_n - 1));
            held_n = 0;
        end
    endfunction

    // Offer one request, with random idle cycles ahead of it; hold until taken.
    task automatic send_request(input t_value v, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.end_of_set <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        take_value(v, eos);
    endtask

    // Write keep_count once the block has drained and gone quiet.
    task automatic write_keep(input t_keep k);
        in_ch.valid <= 1'b0;
        while (kept_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        keep_reg = k;
    endtask

    // Stall the result side at the phase's rate.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest queued one.
    always @(posedge i_clk) begin
        t_kept_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (kept_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kept_value=%0d final_res=%0b",
                                        out_ch.kept_value, out_ch.final_res));
            end else begin
                want = kept_q.pop_front();
                if (out_ch.kept_value !== want.kept_value ||
                    out_ch.final_res !== want.final_res)
                    flag_mismatch($sformatf(
                        "kept_value exp %0d got %0d, final_res exp %0b got %0b",
                        want.kept_value, out_ch.kept_value,
                        want.final_res, out_ch.final_res));
            end
        end
    end

    initial begin
        int     set_left;
        t_value v;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.end_of_set = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatch_count   = 0;
        held_n           = 0;
        keep_reg         = SKS_KEEP_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; rows with has_exp set replace the predicted value.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_KEEP) begin
                write_keep(dir_rows[r].keep);
            end else begin
                send_request(dir_rows[r].value, dir_rows[r].eos);
                if (dir_rows[r].has_exp) begin
                    void'(kept_q.pop_back());
                    queue_result(dir_rows[r].exp_value, 1'b1);
                end
            end
        end

        // Random sets, mostly short, some longer than any k.
        set_left = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_keep(ph < RAND_PHASES - 1 ? keep_plan[ph] : t_keep'($urandom_range(31)));
            send_idle_pct  = send_idle_plan[ph % 4];
            recv_stall_pct = recv_stall_plan[ph % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (set_left == 0)
                    set_left = ($urandom_range(3) == 0) ? $urandom_range(40, 17)
                                                        : $urandom_range(16, 1);
                case ($urandom_range(9))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2, 3, 4: v = t_value'(int'($urandom_range(15)) - 8);
                    default: v = t_value'($urandom);
                endcase
                set_left--;
                send_request(v, set_left == 0);
            end
        end

        // Close any open set, then let the last results drain.
        send_request(t_value'($urandom), 1'b1);
        in_ch.valid <= 1'b0;
        while (kept_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: streaming_k_smallest.f
rtl/sks_pkg.sv
rtl/sks_in_if.sv
rtl/sks_out_if.sv
rtl/sks_insert.sv
rtl/sks_drain.sv
rtl/streaming_k_smallest.sv
verif/streaming_k_smallest_tb.sv
